// ----- rtl/fralu_pkg.sv -----
// Shared types and constants for the four-register ALU machine.
`default_nettype none

package fralu_pkg;

  // Register and index widths.
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 2;
  localparam int CNT_W     = $clog2(DATA_W);
  localparam int DEF_NUM_REGS = 4;

  // Instruction codes.
  typedef enum logic [3:0] {
    OP_IN   = 4'd0,
    OP_OUT  = 4'd1,
    OP_MOV  = 4'd2,
    OP_XCHG = 4'd3,
    OP_ADD  = 4'd4,
    OP_SUB  = 4'd5,
    OP_MUL  = 4'd6,
    OP_DIV  = 4'd7,
    OP_MOD  = 4'd8,
    OP_AND  = 4'd9,
    OP_OR   = 4'd10,
    OP_XOR  = 4'd11
  } op_t;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_OPER,
    S_RUN,
    S_XCHG,
    S_DONE
  } state_t;

  // Execution unit states.
  typedef enum logic [2:0] {
    U_IDLE,
    U_SIMPLE,
    U_NEGA,
    U_NEGB,
    U_ITER,
    U_FIX,
    U_DONE
  } unit_state_t;

  // Request from the sequencer to the execution unit.
  typedef struct packed {
    logic start;
    op_t  op;
  } exec_req_t;

endpackage

`default_nettype wire

// ----- rtl/four_register_alu_machine_core.sv -----
// Top level: instruction sequencer, register file, execution unit and result register.
//
// Usage: each input word is one decoded instruction, taken when in_valid and
// in_ready are both high. Every instruction yields exactly one result word on
// the output channel (out_value, out_valid, divide_by_zero), handed over when
// res_valid and res_ready are both high.
// IN, OUT, MOV, undefined codes and DIV or MOD with a zero divisor finish in
// decode; XCHG adds a second write state; ADD, SUB, AND, OR and XOR use the
// simple step of the execution unit. MUL, DIV and MOD run one bit per cycle
// through the single 64-bit adder of the execution unit, 64 steps, preceded for
// DIV and MOD by operand negation and followed by a sign fix-up step.
// One instruction is in flight at a time; in_ready is high only while the
// sequencer is idle, so it rises in the cycle after the previous result
// enters the result register.
// The result register lets the next instruction be taken while the previous
// result still waits; if the receiver stalls, a finished instruction holds in
// its last state until the result register is free.
// Reset clears all registers to zero (through per-register valid bits),
// empties the result register and returns the sequencer to idle.
`default_nettype none

module four_register_alu_machine_core
  import fralu_pkg::*;
#(
  parameter int NUM_REGS = DEF_NUM_REGS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [3:0]               operation,
  input  wire logic [REG_IDX_W-1:0]     dest_reg,
  input  wire logic [REG_IDX_W-1:0]     src_a_reg,
  input  wire logic [REG_IDX_W-1:0]     src_b_reg,
  input  wire logic                     three_operand,
  input  wire logic signed [DATA_W-1:0] load_value,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output logic signed [DATA_W-1:0]      out_value,
  output logic                          out_valid,
  output logic                          divide_by_zero
);

  state_t                 state, state_next;
  op_t                    op_q, op_in;
  logic [REG_IDX_W-1:0]   dst_q, sa_q;
  logic [DATA_W-1:0]      imm_q;
  logic [DATA_W-1:0]      p_value, p_value_next;
  logic                   p_outv, p_outv_next;
  logic                   p_dz, p_dz_next;

  logic                   accept, arith_in, out_free, out_load;
  logic [REG_IDX_W-1:0]   rd_addr0, rd_addr1, wr_addr;
  logic [DATA_W-1:0]      x, y, wr_data, ex_result;
  logic                   wr_en, ex_done;
  exec_req_t              req;

  assign op_in    = op_t'(operation);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !res_valid || res_ready;
  assign out_load = (state == S_DONE) && out_free;

  // Arithmetic in three-operand form reads src_a and src_b; all else reads dest and src_a.
  assign arith_in = (operation >= 4'(OP_ADD)) && (operation <= 4'(OP_XOR));
  assign rd_addr0 = (arith_in && three_operand) ? src_a_reg : dest_reg;
  assign rd_addr1 = (arith_in && three_operand) ? src_b_reg : src_a_reg;

  fralu_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (x),
    .rd_data1 (y),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  fralu_exec u_exec (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .opnd_a (x),
    .opnd_b (y),
    .done   (ex_done),
    .result (ex_result)
  );

  // Capture the instruction word.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op_in;
      dst_q <= dest_reg;
      sa_q  <= src_a_reg;
      imm_q <= load_value;
    end
  end

  // Sequencer: next state, register writes and the pending result.
  always_comb begin
    state_next   = state;
    wr_en        = 1'b0;
    wr_addr      = dst_q;
    wr_data      = y;
    req.start    = 1'b0;
    req.op       = op_q;
    p_value_next = p_value;
    p_outv_next  = p_outv;
    p_dz_next    = p_dz;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          p_value_next = '0;
          p_outv_next  = 1'b0;
          p_dz_next    = 1'b0;
          state_next   = S_OPER;
        end
      end
      S_OPER: begin
        unique case (op_q) inside
          OP_IN: begin
            wr_en      = 1'b1;
            wr_data    = imm_q;
            state_next = S_DONE;
          end
          OP_OUT: begin
            p_value_next = x;
            p_outv_next  = 1'b1;
            state_next   = S_DONE;
          end
          OP_MOV: begin
            wr_en      = 1'b1;
            state_next = S_DONE;
          end
          OP_XCHG: begin
            wr_en      = 1'b1;
            state_next = S_XCHG;
          end
          OP_DIV, OP_MOD: begin
            if (y == '0) begin
              p_dz_next  = 1'b1;
              state_next = S_DONE;
            end else begin
              req.start  = 1'b1;
              state_next = S_RUN;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR: begin
            req.start  = 1'b1;
            state_next = S_RUN;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_XCHG: begin
        // Second half of the swap: old dest value goes to src_a.
        wr_en      = 1'b1;
        wr_addr    = sa_q;
        wr_data    = x;
        state_next = S_DONE;
      end
      S_RUN: begin
        if (ex_done) begin
          wr_en      = 1'b1;
          wr_data    = ex_result;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    p_value <= p_value_next;
    p_outv  <= p_outv_next;
    p_dz    <= p_dz_next;
  end

  // Result register toward the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value      <= p_value;
      out_valid      <= p_outv;
      divide_by_zero <= p_dz;
    end
  end

  // The register file is never written while the sequencer waits for a word.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("register write while idle");

  // The execution unit only finishes while the sequencer waits for it.
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    ex_done |-> (state == S_RUN))
    else $error("execution unit finished outside of run state");

  // An accepted word always moves on to operand decode.
  a_accept_oper: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_OPER))
    else $error("accepted word did not enter decode");

  // A result word carries a value only for OUT and never both flags.
  a_result_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!(out_valid && divide_by_zero) && (out_valid || out_value == '0)))
    else $error("malformed result word");

endmodule

`default_nettype wire

// ----- rtl/fralu_regfile.sv -----
// Register file with valid bits, one write port and two registered read ports.
`default_nettype none

module fralu_regfile
  import fralu_pkg::*;
#(
  parameter int NUM_REGS = DEF_NUM_REGS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire logic [REG_IDX_W-1:0] rd_addr0,
  input  wire logic [REG_IDX_W-1:0] rd_addr1,
  output logic      [DATA_W-1:0]    rd_data0,
  output logic      [DATA_W-1:0]    rd_data1,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]    wr_data
);

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;

  logic          rd_ok0, rd_ok1, wr_ok;
  logic [AW-1:0] ra0, ra1, wa;

  // Index mapping; indexes at or above the register count are ignored.
  assign ra0    = AW'(rd_addr0);
  assign ra1    = AW'(rd_addr1);
  assign wa     = AW'(wr_addr);
  assign rd_ok0 = 32'(rd_addr0) < 32'(NUM_REGS);
  assign rd_ok1 = 32'(rd_addr1) < 32'(NUM_REGS);
  assign wr_ok  = 32'(wr_addr) < 32'(NUM_REGS);

  // Valid bits make never-written registers read as zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en && wr_ok) begin
      vld[wa] <= 1'b1;
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wa] <= wr_data;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= (rd_ok0 && vld[ra0]) ? mem[ra0] : '0;
      rd_data1 <= (rd_ok1 && vld[ra1]) ? mem[ra1] : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fralu_exec.sv -----
// Shared 64-bit adder with a sequencer for add, subtract, logic, multiply, divide and modulo.
`default_nettype none

module fralu_exec
  import fralu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire exec_req_t         req,
  input  wire logic [DATA_W-1:0] opnd_a,
  input  wire logic [DATA_W-1:0] opnd_b,
  output logic                   done,
  output logic      [DATA_W-1:0] result
);

  unit_state_t       ustate, ustate_next;
  op_t               op_r, op_r_next;
  logic [DATA_W-1:0] acc, acc_next;
  logic [DATA_W-1:0] quo, quo_next;
  logic [DATA_W-1:0] opd, opd_next;
  logic [DATA_W-1:0] res, res_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              neg_res, neg_res_next;

  logic [DATA_W-1:0] add_a, add_b, add_b_eff, sum, shifted, fix_val;
  logic              add_sub, carry;

  // Partial remainder shifted left by one with the next dividend bit.
  assign shifted = {acc[DATA_W-2:0], quo[DATA_W-1]};
  assign fix_val = (op_r == OP_DIV) ? quo : acc;

  // The one adder; carry out is the no-borrow flag when subtracting.
  assign add_b_eff    = add_sub ? ~add_b : add_b;
  assign {carry, sum} = {1'b0, add_a} + {1'b0, add_b_eff} + (DATA_W+1)'(add_sub);

  // Adder operand selection by step.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (ustate)
      U_SIMPLE: begin
        add_a   = quo;
        add_b   = opd;
        add_sub = (op_r == OP_SUB);
      end
      U_NEGA: begin
        add_b   = quo;
        add_sub = 1'b1;
      end
      U_NEGB: begin
        add_b   = opd;
        add_sub = 1'b1;
      end
      U_ITER: begin
        if (op_r == OP_MUL) begin
          add_a = acc;
          add_b = opd;
        end else begin
          add_a   = shifted;
          add_b   = opd;
          add_sub = 1'b1;
        end
      end
      U_FIX: begin
        add_b   = fix_val;
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  // Step sequencer.
  always_comb begin
    ustate_next  = ustate;
    op_r_next    = op_r;
    acc_next     = acc;
    quo_next     = quo;
    opd_next     = opd;
    res_next     = res;
    cnt_next     = cnt;
    neg_res_next = neg_res;
    unique case (ustate)
      U_IDLE: begin
        if (req.start) begin
          op_r_next    = req.op;
          quo_next     = opnd_a;
          opd_next     = opnd_b;
          acc_next     = '0;
          cnt_next     = CNT_W'(DATA_W - 1);
          neg_res_next = 1'b0;
          case (req.op)
            OP_MUL: begin
              ustate_next = U_ITER;
            end
            OP_DIV: begin
              neg_res_next = opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1];
              ustate_next  = U_NEGA;
            end
            OP_MOD: begin
              neg_res_next = opnd_a[DATA_W-1];
              ustate_next  = U_NEGA;
            end
            default: begin
              ustate_next = U_SIMPLE;
            end
          endcase
        end
      end
      U_SIMPLE: begin
        case (op_r)
          OP_AND:  res_next = quo & opd;
          OP_OR:   res_next = quo | opd;
          OP_XOR:  res_next = quo ^ opd;
          default: res_next = sum;
        endcase
        ustate_next = U_DONE;
      end
      U_NEGA: begin
        if (quo[DATA_W-1]) begin
          quo_next = sum;
        end
        ustate_next = U_NEGB;
      end
      U_NEGB: begin
        if (opd[DATA_W-1]) begin
          opd_next = sum;
        end
        ustate_next = U_ITER;
      end
      U_ITER: begin
        if (op_r == OP_MUL) begin
          // Shift-and-add: one multiplier bit per step.
          if (quo[0]) begin
            acc_next = sum;
          end
          opd_next = {opd[DATA_W-2:0], 1'b0};
          quo_next = {1'b0, quo[DATA_W-1:1]};
        end else begin
          // Restoring division: one quotient bit per step.
          acc_next = carry ? sum : shifted;
          quo_next = {quo[DATA_W-2:0], carry};
        end
        cnt_next = cnt - CNT_W'(1);
        if (cnt == '0) begin
          ustate_next = U_FIX;
        end
      end
      U_FIX: begin
        res_next    = neg_res ? sum : fix_val;
        ustate_next = U_DONE;
      end
      U_DONE: begin
        ustate_next = U_IDLE;
      end
      default: begin
        ustate_next = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
    end else begin
      ustate <= ustate_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_r_next;
    acc     <= acc_next;
    quo     <= quo_next;
    opd     <= opd_next;
    res     <= res_next;
    cnt     <= cnt_next;
    neg_res <= neg_res_next;
  end

  assign done   = (ustate == U_DONE);
  assign result = res;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the four-register ALU machine core.
module tb;
  import fralu_pkg::*;

  // Codes that the instruction decoder does not define.
  localparam logic [3:0] OP_UNDEF_FIRST = 4'd12;
  localparam logic [3:0] OP_UNDEF_LAST  = 4'd15;

  // Register names.
  localparam logic [REG_IDX_W-1:0] REG_A = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_B = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_C = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_D = 2'd3;

  // Operand extremes.
  localparam logic [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VALUE_ZERO = '0;
  localparam logic [DATA_W-1:0] VALUE_ONE = 64'd1;
  localparam logic [DATA_W-1:0] VALUE_NEG_ONE = '1;

  // Cycles to watch for stray words after the last expected one.
  localparam int QUIET_CYCLES = 150;
  localparam int MAX_GAP = 20;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              emitted;
    logic              div_zero;
  } result_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [3:0]               operation = OP_IN;
  logic [REG_IDX_W-1:0]     dest_reg = REG_A;
  logic [REG_IDX_W-1:0]     src_a_reg = REG_A;
  logic [REG_IDX_W-1:0]     src_b_reg = REG_A;
  logic                     three_operand = 1'b0;
  logic signed [DATA_W-1:0] load_value = '0;
  logic                     res_valid;
  logic                     res_ready = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_valid;
  logic                     divide_by_zero;

  // Shadow register file and the words still to come back.
  logic [DATA_W-1:0] shadow_regs [4];
  result_word_t      awaited_words [$];
  result_word_t      head_word;
  int                error_count = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;

  four_register_alu_machine_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .dest_reg(dest_reg),
    .src_a_reg(src_a_reg),
    .src_b_reg(src_b_reg),
    .three_operand(three_operand),
    .load_value(load_value),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .out_value(out_value),
    .out_valid(out_valid),
    .divide_by_zero(divide_by_zero)
  );

  always #5 clk = ~clk;

  // Absolute value of a two's complement pattern; the minimum maps to 2^63.
  function automatic logic [DATA_W-1:0] magnitude_of(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
  endfunction

  // Executes one instruction on the shadow registers and returns its result word.
  function automatic result_word_t execute_instruction(
    input logic [3:0]           code,
    input logic [REG_IDX_W-1:0] dst,
    input logic [REG_IDX_W-1:0] sa,
    input logic [REG_IDX_W-1:0] sb,
    input logic                 three,
    input logic [DATA_W-1:0]    imm
  );
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] t;
    result_word_t      res;
    res = '0;
    x = three ? shadow_regs[sa] : shadow_regs[dst];
    y = three ? shadow_regs[sb] : shadow_regs[sa];
    case (code) inside
      OP_IN: shadow_regs[dst] = imm;
      OP_OUT: begin
        res.value = shadow_regs[dst];
        res.emitted = 1'b1;
      end
      OP_MOV: shadow_regs[dst] = shadow_regs[sa];
      OP_XCHG: begin
        t = shadow_regs[dst];
        shadow_regs[dst] = shadow_regs[sa];
        shadow_regs[sa] = t;
      end
      OP_ADD: shadow_regs[dst] = x + y;
      OP_SUB: shadow_regs[dst] = x - y;
      OP_MUL: shadow_regs[dst] = x * y;
      OP_AND: shadow_regs[dst] = x & y;
      OP_OR:  shadow_regs[dst] = x | y;
      OP_XOR: shadow_regs[dst] = x ^ y;
      OP_DIV, OP_MOD: begin
        // A zero divisor keeps dest and raises the flag.
        if (y == '0) begin
          res.div_zero = 1'b1;
        end else if (code == OP_DIV) begin
          q = magnitude_of(x) / magnitude_of(y);
          if (x[DATA_W-1] ^ y[DATA_W-1]) q = ~q + DATA_W'(1);
          shadow_regs[dst] = q;
        end else begin
          q = magnitude_of(x) % magnitude_of(y);
          if (x[DATA_W-1]) q = ~q + DATA_W'(1);
          shadow_regs[dst] = q;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Each accepted result word is compared with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected word, out_value", out_value, '0);
      end else begin
        head_word = awaited_words.pop_front();
        if (out_value !== head_word.value)
          report_mismatch("out_value", out_value, head_word.value);
        if (out_valid !== head_word.emitted)
          report_mismatch("out_valid", DATA_W'(out_valid), DATA_W'(head_word.emitted));
        if (divide_by_zero !== head_word.div_zero)
          report_mismatch("divide_by_zero", DATA_W'(divide_by_zero),
                          DATA_W'(head_word.div_zero));
      end
    end
  end

  // Sends one instruction word. Called just after a rising edge; returns at the edge
  // where the word is taken, with in_valid still high.
  task automatic send_instruction(
    input logic [3:0]           code,
    input logic [REG_IDX_W-1:0] dst,
    input logic [REG_IDX_W-1:0] sa,
    input logic [REG_IDX_W-1:0] sb,
    input logic                 three,
    input logic [DATA_W-1:0]    imm
  );
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= code;
    dest_reg <= dst;
    src_a_reg <= sa;
    src_b_reg <= sb;
    three_operand <= three;
    load_value <= imm;
    awaited_words.push_back(execute_instruction(code, dst, sa, sb, three, imm));
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender off until every expected word has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_words.size() != 0);
  endtask

  // Mix of extremes, values near zero and full-width patterns.
  function automatic logic [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9)) inside
      0: v = VALUE_MIN;
      1: v = VALUE_MAX;
      2: v = VALUE_ZERO;
      3: v = VALUE_NEG_ONE;
      4: v = VALUE_ONE;
      5, 6: begin
        v = DATA_W'($urandom_range(0, 32));
        v = v - 64'd16;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Registers A and D read zero after reset.
  task automatic test_reset_values();
    send_instruction(OP_OUT, REG_A, REG_A, REG_A, 1'b0, VALUE_MAX);
    send_instruction(OP_OUT, REG_D, REG_D, REG_D, 1'b1, VALUE_MIN);
  endtask

  // Minimum over minus one for divide and modulo, zero divisors in both forms.
  task automatic test_division_corners();
    send_instruction(OP_IN, REG_A, REG_D, REG_D, 1'b0, VALUE_MIN);
    send_instruction(OP_IN, REG_B, REG_D, REG_D, 1'b1, VALUE_NEG_ONE);
    send_instruction(OP_DIV, REG_A, REG_B, REG_D, 1'b0, VALUE_ZERO);
    send_instruction(OP_OUT, REG_A, REG_A, REG_A, 1'b0, VALUE_ZERO);
    send_instruction(OP_MOD, REG_D, REG_A, REG_B, 1'b1, VALUE_ZERO);
    send_instruction(OP_IN, REG_C, REG_A, REG_A, 1'b0, VALUE_ZERO);
    send_instruction(OP_DIV, REG_A, REG_C, REG_D, 1'b0, VALUE_ZERO);
    send_instruction(OP_MOD, REG_D, REG_B, REG_C, 1'b1, VALUE_ZERO);
    send_instruction(OP_OUT, REG_D, REG_A, REG_A, 1'b0, VALUE_ZERO);
  endtask

  // Swap with itself keeps the value; copy and swap between registers.
  task automatic test_exchange_and_move();
    send_instruction(OP_IN, REG_C, REG_A, REG_A, 1'b0, VALUE_MAX);
    send_instruction(OP_XCHG, REG_C, REG_C, REG_A, 1'b0, VALUE_ZERO);
    send_instruction(OP_XCHG, REG_A, REG_C, REG_B, 1'b1, VALUE_ZERO);
    send_instruction(OP_MOV, REG_B, REG_A, REG_C, 1'b0, VALUE_ZERO);
    send_instruction(OP_OUT, REG_C, REG_A, REG_A, 1'b0, VALUE_ZERO);
  endtask

  // Add, subtract, multiply and each logic operation in alternating forms, chained.
  task automatic test_arith_and_logic();
    send_instruction(OP_ADD, REG_A, REG_C, REG_D, 1'b0, VALUE_ZERO);
    send_instruction(OP_SUB, REG_D, REG_C, REG_A, 1'b1, VALUE_ZERO);
    send_instruction(OP_MUL, REG_B, REG_D, REG_D, 1'b0, VALUE_ZERO);
    send_instruction(OP_AND, REG_C, REG_D, REG_B, 1'b1, VALUE_ZERO);
    send_instruction(OP_OR, REG_A, REG_B, REG_C, 1'b0, VALUE_ZERO);
    send_instruction(OP_XOR, REG_D, REG_A, REG_C, 1'b1, VALUE_ZERO);
    send_instruction(OP_OUT, REG_D, REG_A, REG_A, 1'b0, VALUE_ZERO);
  endtask

  // Undefined codes change nothing and return an all-zero word.
  task automatic test_undefined_codes();
    logic [3:0] code;
    for (code = OP_UNDEF_FIRST; code != OP_IN; code++)
      send_instruction(code, REG_D, REG_C, REG_B, code[0], VALUE_NEG_ONE);
  endtask

  // Random instruction streams, weighted toward loads and reads.
  task automatic test_random_programs(input int count);
    int         pick;
    logic [3:0] code;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) code = 4'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
      else if (pick < 23) code = OP_OUT;
      else if (pick < 38) code = OP_IN;
      else code = 4'($urandom_range(OP_MOV, OP_XOR));
      send_instruction(code, REG_IDX_W'($urandom_range(0, 3)),
                       REG_IDX_W'($urandom_range(0, 3)),
                       REG_IDX_W'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), random_operand());
    end
  endtask

  // Run limit.
  initial begin
    #10_000_000;
    $display("four_register_alu_machine_core test failed");
    $finish;
  end

  initial begin
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Light sender gaps, heavy receiver stalls.
    send_idle_pct = 6;
    recv_idle_pct = 80;
    test_reset_values();
    test_division_corners();
    test_exchange_and_move();
    test_arith_and_logic();
    test_undefined_codes();
    test_random_programs(500);
    pause_until_drained();

    // Heavy sender gaps, light receiver stalls.
    send_idle_pct = 80;
    recv_idle_pct = 6;
    test_random_programs(500);
    pause_until_drained();

    // Back to back.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_programs(500);
    pause_until_drained();
    repeat (QUIET_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("four_register_alu_machine_core test passed");
    end else begin
      $display("four_register_alu_machine_core test failed");
    end
    $finish;
  end

endmodule

// ----- four_register_alu_machine_core.f -----
rtl/fralu_pkg.sv
rtl/fralu_regfile.sv
rtl/fralu_exec.sv
rtl/four_register_alu_machine_core.sv
tb/tb.sv
